// ===== rtl/ksoa_pkg.sv =====
// Shared types and constants for the keypad scanner with override and autorepeat.
// Holds the key priority table, override masks and the action codes.
// No dependencies.
package ksoa_pkg;

	localparam int unsigned NUM_WORDS  = 3;
	localparam int unsigned NUM_KEYS   = 15;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned KEY_W      = 4;
	localparam int unsigned DELAY_W    = 16;
	localparam int unsigned PLEN_W     = 16;
	localparam int unsigned ACTION_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;

	// Action codes carried in tuser.
	localparam logic [ACTION_W-1:0] ACT_SCAN        = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_OVR_PRESS   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_OVR_RELEASE = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_OVR_CLEAR   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OVR_EN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_EN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DLY  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DLY = 2'd3;

	localparam logic [DELAY_W-1:0] FIRST_DLY_RST  = 16'd500;
	localparam logic [DELAY_W-1:0] REPEAT_DLY_RST = 16'd175;

	localparam logic [WORD_W-1:0] READONLY_BIT = 32'h0002_0000;
	localparam logic [WORD_W-1:0] REMOTE_BIT   = 32'h0004_0000;
	localparam int unsigned       REMOTE_POS   = 18;

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word3_t;

	// Override masks per word group.
	localparam word3_t OVR_MASK = '{32'h0000_FF50, 32'h0000_F000, 32'h0000_0000};

	typedef logic [1:0] group_t;

	// Key priority table: word group and bit mask of each position.
	localparam group_t KEY_GROUP [NUM_KEYS] = '{
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1
	};
	localparam logic [WORD_W-1:0] KEY_MASK [NUM_KEYS] = '{
		32'h0000_0010, 32'h0000_0040, 32'h0000_0100, 32'h0000_0200, 32'h0000_0400,
		32'h0000_0800, 32'h0000_1000, 32'h0000_2000, 32'h0000_4000, 32'h0000_8000,
		32'h0000_4000, 32'h0000_8000, 32'h0000_3000, 32'h0000_2000, 32'h0000_1000
	};

	// Key decode results passed to the top level.
	typedef struct packed {
		logic [KEY_W-1:0]    pressed;
		logic [KEY_W-1:0]    clicked;
		logic [NUM_KEYS-1:0] down;
	} key_stat_t;

endpackage

// ===== rtl/ksoa_keys.sv =====
// Key decode: per-key down and click flags and the first-match priority encode.
// Depends on ksoa_pkg for the key table and the key_stat_t type.
module ksoa_keys (
	input  ksoa_pkg::word3_t    cur_words,
	input  ksoa_pkg::word3_t    prev_words,
	output ksoa_pkg::key_stat_t key_stat
);
	import ksoa_pkg::*;

	logic [NUM_KEYS-1:0] down;
	logic [NUM_KEYS-1:0] click;

	// A key is down when all of its mask bits are low; clicked when one was high before.
	always_comb begin
		for (int i = 0; i < NUM_KEYS; i++) begin
			down[i]  = (cur_words[KEY_GROUP[i]] & KEY_MASK[i]) == '0;
			click[i] = down[i] && ((prev_words[KEY_GROUP[i]] & KEY_MASK[i]) != '0);
		end
	end

	// Lowest table position wins; key codes are position plus one.
	always_comb begin
		key_stat.pressed = '0;
		key_stat.clicked = '0;
		key_stat.down    = down;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (down[i]) begin
				key_stat.pressed = KEY_W'(i + 1);
			end
			if (click[i]) begin
				key_stat.clicked = KEY_W'(i + 1);
			end
		end
	end

endmodule

// ===== rtl/keypad_scan_override_autorepeat.sv =====
// Keypad scanner with software key override, autorepeat and remote pulse timing.
// A scan result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the result is taken; the result register frees as it is taken.
// Override requests update the override image when accepted and produce no result.
// Reset (arst_n low) restores all key words to ones, clears autorepeat and pulse
// state and loads the reset values of the configuration registers.
module keypad_scan_override_autorepeat #(
	parameter int unsigned PULSE_COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write port.
	input  logic                       cfg_we,
	input  logic [ksoa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ksoa_pkg::DELAY_W-1:0]   cfg_data,
	// Request stream.
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata, low bit up: key_index[3:0], raw_word0[35:4], raw_word1[67:36],
	// raw_word2[99:68], tick_now[131:100], zero pad[135:132].
	input  logic [135:0]               s_axis_tdata,
	// tuser: action[1:0].
	input  logic [ksoa_pkg::ACTION_W-1:0]  s_axis_tuser,
	// Result stream.
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// tdata, low bit up: status_word0[31:0], status_word1[63:32], status_word2[95:64],
	// pressed_key[99:96], clicked_key[103:100], repeat_key[107:104],
	// remote_level[108], pulse_done[109], pulse_length[125:110], zero pad[127:126].
	output logic [127:0]               m_axis_tdata
);
	import ksoa_pkg::*;

	localparam int unsigned CNT_W = (PULSE_COUNT_BITS > PLEN_W) ? PULSE_COUNT_BITS : PLEN_W;

	// Configuration registers.
	logic               ovr_en_q;
	logic               remote_en_q;
	logic [DELAY_W-1:0] first_dly_q;
	logic [DELAY_W-1:0] repeat_dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_en_q     <= 1'b0;
			remote_en_q  <= 1'b0;
			first_dly_q  <= FIRST_DLY_RST;
			repeat_dly_q <= REPEAT_DLY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OVR_EN:     ovr_en_q     <= cfg_data[0];
				CFG_REMOTE_EN:  remote_en_q  <= cfg_data[0];
				CFG_FIRST_DLY:  first_dly_q  <= cfg_data;
				CFG_REPEAT_DLY: repeat_dly_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request fields.
	logic [ACTION_W-1:0] action;
	logic [KEY_W-1:0]    key_index;
	word3_t              raw_words;
	logic [WORD_W-1:0]   tick_now;

	assign action       = s_axis_tuser;
	assign key_index    = s_axis_tdata[3:0];
	assign raw_words[0] = s_axis_tdata[35:4];
	assign raw_words[1] = s_axis_tdata[67:36];
	assign raw_words[2] = s_axis_tdata[99:68];
	assign tick_now     = s_axis_tdata[131:100];

	// State.
	word3_t                      cur_q;
	word3_t                      ovr_q;
	logic [KEY_W-1:0]            held_key_q;
	logic [WORD_W-1:0]           held_since_q;
	logic                        repeating_q;
	logic [PULSE_COUNT_BITS-1:0] remote_cnt_q;
	logic                        out_valid_q;

	logic accept;
	logic is_scan;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_scan       = action == ACT_SCAN;

	// Key decode on the incoming words against the words of the last scan.
	key_stat_t key_stat;

	ksoa_keys u_keys (
		.cur_words  (raw_words),
		.prev_words (cur_q),
		.key_stat   (key_stat)
	);

	// Status merge and remote pulse measurement.
	word3_t                      status;
	logic                        rlevel;
	logic                        pdone;
	logic [PLEN_W-1:0]           plen;
	logic [PULSE_COUNT_BITS-1:0] remote_cnt_nxt;
	logic [CNT_W-1:0]            cnt_ext;

	always_comb begin
		for (int i = 0; i < NUM_WORDS; i++) begin
			status[i] = ovr_en_q ? ((raw_words[i] & ~OVR_MASK[i]) | (ovr_q[i] & OVR_MASK[i]))
				: raw_words[i];
		end
		rlevel         = status[2][REMOTE_POS];
		cnt_ext        = CNT_W'(remote_cnt_q);
		pdone          = 1'b0;
		plen           = '0;
		remote_cnt_nxt = remote_cnt_q;
		if (rlevel) begin
			if (remote_cnt_q != '1) begin
				remote_cnt_nxt = remote_cnt_q + 1'b1;
			end
		end else if (remote_cnt_q != '0) begin
			pdone          = 1'b1;
			plen           = (cnt_ext > CNT_W'({PLEN_W{1'b1}})) ? {PLEN_W{1'b1}}
				: cnt_ext[PLEN_W-1:0];
			remote_cnt_nxt = '0;
		end
		if (remote_en_q) begin
			status[2] = status[2] & ~(READONLY_BIT | REMOTE_BIT);
		end else begin
			status[2] = status[2] & ~READONLY_BIT;
		end
	end

	// Autorepeat: a click restarts the hold; a held key fires after the delay.
	logic [KEY_W-1:0]  held_pos;
	logic              held_down;
	logic [WORD_W-1:0] elapsed;
	logic [DELAY_W-1:0] limit;
	logic              fire;
	logic [KEY_W-1:0]  rep_key;
	logic [KEY_W-1:0]  held_key_nxt;
	logic [WORD_W-1:0] held_since_nxt;
	logic              repeating_nxt;

	assign held_pos  = held_key_q - 1'b1;
	assign held_down = (held_key_q != '0) && key_stat.down[held_pos];
	assign elapsed   = tick_now - held_since_q;
	assign limit     = repeating_q ? repeat_dly_q : first_dly_q;
	assign fire      = !elapsed[WORD_W-1] && (elapsed > WORD_W'(limit));

	always_comb begin
		held_key_nxt   = held_key_q;
		held_since_nxt = held_since_q;
		repeating_nxt  = repeating_q;
		rep_key        = '0;
		if (key_stat.clicked != '0) begin
			held_key_nxt   = key_stat.clicked;
			held_since_nxt = tick_now;
			repeating_nxt  = 1'b0;
			rep_key        = key_stat.clicked;
		end else if (held_down) begin
			if (fire) begin
				held_since_nxt = tick_now;
				repeating_nxt  = 1'b1;
				rep_key        = held_key_q;
			end
		end else begin
			held_key_nxt = '0;
		end
	end

	// Override image update for press, release and release-all requests.
	logic [KEY_W-1:0] ovr_pos;
	word3_t           ovr_nxt;

	assign ovr_pos = key_index - 1'b1;

	always_comb begin
		ovr_nxt = ovr_q;
		case (action)
			ACT_OVR_PRESS: begin
				if (key_index != '0) begin
					ovr_nxt[KEY_GROUP[ovr_pos]] = ovr_q[KEY_GROUP[ovr_pos]] & ~KEY_MASK[ovr_pos];
				end
			end
			ACT_OVR_RELEASE: begin
				if (key_index != '0) begin
					ovr_nxt[KEY_GROUP[ovr_pos]] = ovr_q[KEY_GROUP[ovr_pos]] | KEY_MASK[ovr_pos];
				end
			end
			ACT_OVR_CLEAR: begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					ovr_nxt[i] = ovr_q[i] | OVR_MASK[i];
				end
			end
			default: ;
		endcase
	end

	// The override image advances on each accepted request, the scan state only on accepted scans.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= '1;
			ovr_q        <= '1;
			held_key_q   <= '0;
			held_since_q <= '0;
			repeating_q  <= 1'b0;
			remote_cnt_q <= '0;
		end else if (accept) begin
			ovr_q <= ovr_nxt;
			if (is_scan) begin
				cur_q        <= raw_words;
				held_key_q   <= held_key_nxt;
				held_since_q <= held_since_nxt;
				repeating_q  <= repeating_nxt;
				remote_cnt_q <= remote_cnt_nxt;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_scan) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [127:0] out_data_q;

	always_ff @(posedge clk) begin
		if (accept && is_scan) begin
			out_data_q <= {2'b00, plen, pdone, rlevel, rep_key, key_stat.clicked,
				key_stat.pressed, status[2], status[1], status[0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/keypad_scan_override_autorepeat_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the keypad scanner: watches the register port and both streams,
// predicts each scan result and compares it field by field with the block output.
// Depends on ksoa_pkg for the action codes and register indexes.
module keypad_scan_override_autorepeat_checker #(
	parameter int unsigned PULSE_COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ksoa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ksoa_pkg::DELAY_W-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	// tdata, low bit up: key_index, raw_word0, raw_word1, raw_word2, tick_now, pad.
	input  logic [135:0]                      s_axis_tdata,
	// tuser: action.
	input  logic [ksoa_pkg::ACTION_W-1:0]     s_axis_tuser,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata, low bit up: status_word0..2, pressed_key, clicked_key, repeat_key,
	// remote_level, pulse_done, pulse_length, pad.
	input  logic [127:0]                      m_axis_tdata,
	output int unsigned                       pending,
	output int unsigned                       fail_count
);

	import ksoa_pkg::*;

	localparam logic [31:0] RO_BIT   = 32'h0002_0000;
	localparam logic [31:0] LINE_BIT = 32'h0004_0000;

	// Bits of each word group that the override image may replace.
	localparam logic [31:0] MERGE_MASK [3] = '{32'h0000_0000, 32'h0000_F000, 32'h0000_FF50};

	// Priority table: positions 0 to 9 sit in word two, 10 to 14 in word one.
	localparam logic [31:0] PRIO_MASK [15] = '{
		32'h0000_0010, 32'h0000_0040, 32'h0000_0100, 32'h0000_0200, 32'h0000_0400,
		32'h0000_0800, 32'h0000_1000, 32'h0000_2000, 32'h0000_4000, 32'h0000_8000,
		32'h0000_4000, 32'h0000_8000, 32'h0000_3000, 32'h0000_2000, 32'h0000_1000
	};

	typedef struct packed {
		logic [31:0] word0;
		logic [31:0] word1;
		logic [31:0] word2;
		logic [3:0]  pressed;
		logic [3:0]  clicked;
		logic [3:0]  repeated;
		logic        line_level;
		logic        pulse_done;
		logic [15:0] pulse_len;
	} scan_outcome_t;

	// Configuration copy.
	logic        ovr_en;
	logic        line_clear_en;
	logic [15:0] first_wait;
	logic [15:0] repeat_wait;

	// Scanner state copy.
	logic [31:0] prev_words [3];
	logic [31:0] cur_words [3];
	logic [31:0] ovr_image [3];
	logic [3:0]  held_key;
	logic [31:0] held_since;
	logic        repeating;
	logic [PULSE_COUNT_BITS-1:0] line_count;

	scan_outcome_t scans_due [$];
	scan_outcome_t want;
	int unsigned   fails;

	assign fail_count = fails;

	function automatic int group_of(input int pos);
		return (pos < 10) ? 2 : 1;
	endfunction

	// A key is down only when every one of its bits is low.
	function automatic logic key_is_down(input int pos);
		return (cur_words[group_of(pos)] & PRIO_MASK[pos]) == 32'd0;
	endfunction

	// Clicked: down now, and at least one of its bits was high on the previous scan.
	function automatic logic key_is_clicked(input int pos);
		return ((prev_words[group_of(pos)] & PRIO_MASK[pos]) != 32'd0) && key_is_down(pos);
	endfunction

	// Works out the result of one scan request and advances the state.
	task automatic predict_scan(input logic [31:0] r0, r1, r2, input logic [31:0] tick,
			output scan_outcome_t res);
		logic [31:0] raw [3];
		logic [31:0] stat [3];
		logic [31:0] elapsed;
		logic [31:0] limit;
		logic [63:0] count_wide;
		raw[0] = r0;
		raw[1] = r1;
		raw[2] = r2;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			prev_words[i] = cur_words[i];
			cur_words[i] = raw[i];
			stat[i] = ovr_en ? ((raw[i] & ~MERGE_MASK[i]) | (ovr_image[i] & MERGE_MASK[i]))
				: raw[i];
		end

		// Remote line pulse timing, counted in scans.
		res.line_level = (stat[2] & LINE_BIT) != 32'd0;
		if (res.line_level) begin
			if (line_count != '1)
				line_count = line_count + 1'b1;
		end else if (line_count != '0) begin
			count_wide = 64'(line_count);
			res.pulse_done = 1'b1;
			res.pulse_len = (count_wide > 64'hFFFF) ? 16'hFFFF : count_wide[15:0];
			line_count = '0;
		end
		stat[2] = stat[2] & (line_clear_en ? ~(RO_BIT | LINE_BIT) : ~RO_BIT);

		for (int i = 0; i < 15; i++) begin
			if (res.pressed == 4'd0 && key_is_down(i))
				res.pressed = 4'(i + 1);
			if (res.clicked == 4'd0 && key_is_clicked(i))
				res.clicked = 4'(i + 1);
		end

		// Autorepeat: a click restarts timing, a held key repeats once past the delay.
		if (res.clicked != 4'd0) begin
			held_key = res.clicked;
			repeating = 1'b0;
			held_since = tick;
			res.repeated = res.clicked;
		end else if (held_key != 4'd0 && key_is_down(int'(held_key) - 1)) begin
			elapsed = tick - held_since;
			limit = repeating ? {16'd0, repeat_wait} : {16'd0, first_wait};
			if (!elapsed[31] && elapsed > limit) begin
				repeating = 1'b1;
				held_since = tick;
				res.repeated = held_key;
			end
		end else begin
			held_key = 4'd0;
		end

		res.word0 = stat[0];
		res.word1 = stat[1];
		res.word2 = stat[2];
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val, got_val);
		if (got_val !== exp_val) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_en = 1'b0;
			line_clear_en = 1'b0;
			first_wait = 16'd500;
			repeat_wait = 16'd175;
			for (int i = 0; i < 3; i++) begin
				prev_words[i] = '1;
				cur_words[i] = '1;
				ovr_image[i] = '1;
			end
			held_key = 4'd0;
			held_since = 32'd0;
			repeating = 1'b0;
			line_count = '0;
			scans_due.delete();
			fails = 0;
			pending <= 0;
		end else begin
			// Register writes.
			if (cfg_we) begin
				case (cfg_index)
					CFG_OVR_EN:     ovr_en = cfg_data[0];
					CFG_REMOTE_EN:  line_clear_en = cfg_data[0];
					CFG_FIRST_DLY:  first_wait = cfg_data;
					CFG_REPEAT_DLY: repeat_wait = cfg_data;
					default: ;
				endcase
			end

			// Compare a delivered result with the oldest prediction.
			if (m_axis_tvalid && m_axis_tready) begin
				if (scans_due.size() == 0) begin
					$error("Result delivered with no scan request outstanding");
					fails++;
				end else begin
					want = scans_due.pop_front();
					check_field("status_word0", want.word0, m_axis_tdata[31:0]);
					check_field("status_word1", want.word1, m_axis_tdata[63:32]);
					check_field("status_word2", want.word2, m_axis_tdata[95:64]);
					check_field("pressed_key", 32'(want.pressed), 32'(m_axis_tdata[99:96]));
					check_field("clicked_key", 32'(want.clicked), 32'(m_axis_tdata[103:100]));
					check_field("repeat_key", 32'(want.repeated), 32'(m_axis_tdata[107:104]));
					check_field("remote_level", 32'(want.line_level), 32'(m_axis_tdata[108]));
					check_field("pulse_done", 32'(want.pulse_done), 32'(m_axis_tdata[109]));
					check_field("pulse_length", 32'(want.pulse_len),
						32'(m_axis_tdata[125:110]));
				end
			end

			// Apply an accepted request.
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					ACT_SCAN: begin
						predict_scan(s_axis_tdata[35:4], s_axis_tdata[67:36],
							s_axis_tdata[99:68], s_axis_tdata[131:100], want);
						scans_due.push_back(want);
					end
					ACT_OVR_PRESS, ACT_OVR_RELEASE: begin
						if (s_axis_tdata[3:0] != 4'd0) begin
							if (s_axis_tuser == ACT_OVR_PRESS)
								ovr_image[group_of(int'(s_axis_tdata[3:0]) - 1)] &=
									~PRIO_MASK[int'(s_axis_tdata[3:0]) - 1];
							else
								ovr_image[group_of(int'(s_axis_tdata[3:0]) - 1)] |=
									PRIO_MASK[int'(s_axis_tdata[3:0]) - 1];
						end
					end
					ACT_OVR_CLEAR: begin
						for (int i = 0; i < 3; i++)
							ovr_image[i] |= MERGE_MASK[i];
					end
					default: ;
				endcase
			end
			pending <= scans_due.size();
		end
	end

endmodule

// ===== verif/keypad_scan_override_autorepeat_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the keypad scanner: clock, reset, register writes and request and
// result stimulus with random idling; the checker module does all prediction.
// Depends on ksoa_pkg, keypad_scan_override_autorepeat and its checker.
module keypad_scan_override_autorepeat_tb;

	import ksoa_pkg::*;

	localparam int unsigned PULSE_BITS  = 16;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned PHASE_ITEMS = 260;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_OVR_EN;
	logic [DELAY_W-1:0]    cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// tdata, low bit up: key_index, raw_word0, raw_word1, raw_word2, tick_now, pad.
	logic [135:0]          s_axis_tdata = '0;
	// tuser: action.
	logic [ACTION_W-1:0]   s_axis_tuser = ACT_SCAN;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// tdata, low bit up: status_word0..2, pressed_key, clicked_key, repeat_key,
	// remote_level, pulse_done, pulse_length, pad.
	logic [127:0]          m_axis_tdata;
	int unsigned           pending;
	int unsigned           fail_count;

	// Stimulus state.
	int unsigned           cycles = 0;
	int unsigned           calm_items = 0;
	logic [15:0]           first_dly = 16'd500;
	logic [15:0]           repeat_dly = 16'd175;
	logic [31:0]           ticks = 32'd0;
	logic [14:0]           held_keys = '0;
	logic                  line_level = 1'b1;
	int unsigned           line_left = 0;

	keypad_scan_override_autorepeat #(.PULSE_COUNT_BITS(PULSE_BITS)) i_dut (.*);

	keypad_scan_override_autorepeat_checker #(.PULSE_COUNT_BITS(PULSE_BITS)) i_checker (.*);

	always #4 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Gap after a request: mostly none or short, sometimes long, with calm stretches.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm_items != 0) begin
			calm_items--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r == 0)
			calm_items = $urandom_range(20, 60);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Tick advance chosen around the current delays so both sides of each limit occur.
	function automatic logic [31:0] tick_step();
		int unsigned lim;
		int unsigned r;
		lim = $urandom_range(0, 1) ? first_dly : repeat_dly;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(0, lim / 8 + 2);
		if (r < 65)
			return (lim == 0) ? $urandom_range(0, 2) : lim - 1 + $urandom_range(0, 3);
		if (r < 88)
			return $urandom_range(0, 2 * lim + 4);
		if (r < 95)
			return $urandom;
		return 32'h8000_0000 + $urandom_range(0, 8) - 4;
	endfunction

	// Offers one request and waits for it to be taken, then may idle for a random gap.
	task automatic send(input logic [ACTION_W-1:0] act, input logic [3:0] kidx,
			input logic [31:0] w0, w1, w2, t);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {4'd0, t, w2, w1, w0, kidx};
		do @(posedge clk); while (!s_axis_tready);
		gap = pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_scan(input logic [31:0] w0, w1, w2, t);
		send(ACT_SCAN, 4'($urandom), w0, w1, w2, t);
	endtask

	task automatic send_override(input logic [ACTION_W-1:0] act, input logic [3:0] kidx);
		send(act, kidx, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Waits until every scan result has been delivered and the block has gone quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes all four registers; enable bits carry random upper data bits.
	task automatic write_regs(input bit ovr, input bit line_clr, input logic [15:0] first,
			input logic [15:0] rpt);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OVR_EN;
		cfg_data <= {15'($urandom), ovr};
		@(posedge clk);
		cfg_index <= CFG_REMOTE_EN;
		cfg_data <= {15'($urandom), line_clr};
		@(posedge clk);
		cfg_index <= CFG_FIRST_DLY;
		cfg_data <= first;
		@(posedge clk);
		cfg_index <= CFG_REPEAT_DLY;
		cfg_data <= rpt;
		@(posedge clk);
		cfg_we <= 1'b0;
		first_dly = first;
		repeat_dly = rpt;
	endtask

	// One scan of a plausible keypad: keys held over several scans, remote line pulses.
	task automatic keypad_scan();
		logic [31:0] w [3];
		int unsigned r;
		if ($urandom_range(0, 6) == 0) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				held_keys = '0;
			else if (r < 8)
				held_keys = 15'(1) << $urandom_range(0, 14);
			else
				held_keys = held_keys | (15'(1) << $urandom_range(0, 14));
		end
		w[0] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
		w[1] = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h0000_F000) : 32'hFFFF_FFFF;
		w[2] = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h0000_FF50) : 32'hFFFF_FFFF;
		for (int k = 0; k < 15; k++)
			if (held_keys[k])
				w[KEY_GROUP[k]] = w[KEY_GROUP[k]] & ~KEY_MASK[k];

		// Remote line level held for a random run of scans.
		if (line_left == 0) begin
			line_level = ~line_level;
			r = $urandom_range(0, 99);
			line_left = (r < 70) ? $urandom_range(1, 6)
				: (r < 95) ? $urandom_range(7, 40) : $urandom_range(100, 400);
		end
		line_left--;
		w[2][REMOTE_POS] = line_level;

		ticks = ticks + tick_step();
		send_scan(w[0], w[1], w[2], ticks);
	endtask

	// Mostly keypad scans, with override requests and fully random scans mixed in.
	task automatic random_items(input int unsigned n);
		int unsigned r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				send_override(ACT_OVR_PRESS, 4'($urandom));
			else if (r < 10)
				send_override(ACT_OVR_RELEASE, 4'($urandom));
			else if (r < 12)
				send_override(ACT_OVR_CLEAR, 4'($urandom));
			else if (r < 17)
				send_scan($urandom, $urandom, $urandom, $urandom);
			else
				keypad_scan();
		end
	endtask

	// Result side: ready in runs, with gaps and one long hold while requests keep coming.
	initial begin
		int unsigned run_len;
		int unsigned hold;
		bit held_once;
		held_once = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
			m_axis_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (!held_once && cycles > 600) begin
				held_once = 1'b1;
				hold = 300;
			end else if ($urandom_range(0, 299) == 0) begin
				hold = $urandom_range(50, 150);
			end else begin
				hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(4, 30);
			end
			m_axis_tready <= 1'b0;
			repeat (hold) @(posedge clk);
		end
	end

	// Request side and verdict.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with short delays so autorepeat timing shows quickly.
		write_regs(1'b1, 1'b1, 16'd2, 16'd1);
		send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100);
		// Every key down at once; the remote line drops after a one-scan pulse.
		send_scan(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		// Key index zero does nothing, then the override image gets several keys.
		send_override(ACT_OVR_PRESS, 4'd0);
		send_override(ACT_OVR_PRESS, 4'd1);
		send_override(ACT_OVR_PRESS, 4'd10);
		send_override(ACT_OVR_PRESS, 4'd13);
		send_override(ACT_OVR_PRESS, 4'd15);
		send_override(ACT_OVR_RELEASE, 4'd0);
		send_override(ACT_OVR_RELEASE, 4'd15);
		send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd10);
		// Release all ignores its key index.
		send_override(ACT_OVR_CLEAR, 4'd7);
		send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd20);
		// Multi-bit key: one half goes down first, then the other half completes it.
		send_scan(32'hFFFF_FFFF, ~32'h0000_1000, 32'hFFFF_FFFF, 32'd30);
		send_scan(32'hFFFF_FFFF, ~32'h0000_3000, 32'hFFFF_FFFF, 32'd31);
		// Held key: equal to the delay does not repeat, one past it does.
		send_scan(32'hFFFF_FFFF, ~32'h0000_3000, 32'hFFFF_FFFF, 32'd33);
		send_scan(32'hFFFF_FFFF, ~32'h0000_3000, 32'hFFFF_FFFF, 32'd34);
		send_scan(32'hFFFF_FFFF, ~32'h0000_3000, 32'hFFFF_FFFF, 32'd35);
		send_scan(32'hFFFF_FFFF, ~32'h0000_3000, 32'hFFFF_FFFF, 32'd36);
		// Elapsed time past half the counter range counts as negative.
		send_scan(32'hFFFF_FFFF, ~32'h0000_3000, 32'hFFFF_FFFF, 32'h8000_0024);
		// Timing across the wrap of the tick counter.
		send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		send_scan(32'hFFFF_FFFF, ~32'h0000_4000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_scan(32'hFFFF_FFFF, ~32'h0000_4000, 32'hFFFF_FFFF, 32'd1);
		// Held key released: no event.
		send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);

		// Random phases over several register settings, extremes included.
		settle();
		write_regs(1'b0, 1'b0, FIRST_DLY_RST, REPEAT_DLY_RST);
		random_items(PHASE_ITEMS);
		settle();
		write_regs(1'b1, 1'b0, 16'd0, 16'd0);
		random_items(PHASE_ITEMS);
		settle();
		write_regs(1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
		random_items(PHASE_ITEMS);
		settle();
		write_regs(1'b1, 1'b1, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)));
		random_items(PHASE_ITEMS);
		settle();
		write_regs(1'b1, 1'b1, 16'hFFFF, 16'd0);
		random_items(PHASE_ITEMS);
		settle();
		write_regs(1'b0, 1'b0, 16'd0, 16'hFFFF);
		random_items(PHASE_ITEMS);
		settle();
		write_regs(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom_range(0, 300)));
		random_items(PHASE_ITEMS);

		settle();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
